// File: rtl/mau_pkg.sv
// ----------------------------------------------------------------------------
// Modular arithmetic unit package
// Operation codes and fixed field widths shared by the interfaces and core.
// ----------------------------------------------------------------------------
package mau_pkg;

	localparam int FUNC_WIDTH    = 3;
	localparam int EXP_WIDTH     = 63;
	localparam int RAW_WIDTH     = 64;
	localparam int RAW_CNT_WIDTH = $clog2(RAW_WIDTH);

	localparam logic [63:0] MODULUS_RESET = 64'd998244353;

	typedef enum logic [FUNC_WIDTH-1:0] {
		FN_ADD    = 3'd0,
		FN_SUB    = 3'd1,
		FN_MUL    = 3'd2,
		FN_DIV    = 3'd3,
		FN_POW    = 3'd4,
		FN_REDUCE = 3'd5
	} func_t;

endpackage

// File: rtl/mau_if.sv
// ----------------------------------------------------------------------------
// Modular arithmetic unit channels
// Request, response and modulus write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface mau_in_if #(parameter int RESIDUE_WIDTH = 31);
	logic                              valid;
	logic                              ready;
	logic [mau_pkg::FUNC_WIDTH-1:0]    func;
	logic [RESIDUE_WIDTH-1:0]          operand_a;
	logic [RESIDUE_WIDTH-1:0]          operand_b;
	logic [mau_pkg::EXP_WIDTH-1:0]     exponent;
	logic signed [mau_pkg::RAW_WIDTH-1:0] raw_value;

	modport source (output valid, func, operand_a, operand_b, exponent, raw_value,
		input ready);
	modport sink (input valid, func, operand_a, operand_b, exponent, raw_value,
		output ready);
endinterface

interface mau_out_if #(parameter int RESIDUE_WIDTH = 31);
	logic                     valid;
	logic                     ready;
	logic [RESIDUE_WIDTH-1:0] result;
	logic                     a_less_b;
	logic                     a_equal_b;
	logic                     operand_error;

	modport source (output valid, result, a_less_b, a_equal_b, operand_error,
		input ready);
	modport sink (input valid, result, a_less_b, a_equal_b, operand_error,
		output ready);
endinterface

interface mau_cfg_if #(parameter int RESIDUE_WIDTH = 31);
	logic                     valid;
	logic                     ready;
	logic [RESIDUE_WIDTH-1:0] modulus;

	modport source (output valid, modulus, input ready);
	modport sink (input valid, modulus, output ready);
endinterface

// File: rtl/modular_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// Modular arithmetic unit core
// Add, subtract, multiply, Fermat divide, power and signed reduce modulo a
// programmable modulus, using a bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// The req channel takes one operation per transfer and the rsp channel
// returns one result per operation, in order. The cfg channel writes the
// modulus and is always ready; the user must see that it is written only
// while the unit is idle, as the block itself does not enforce it. Add,
// subtract, errors and unused codes go straight from the idle state to the
// finish state. Multiply runs the shift-and-add multiplier, one multiplier
// bit per cycle. Power and divide run square-and-multiply over that same
// multiplier, one or two products per exponent bit, and divide ends with a
// product by the dividend. Reduce shifts the 64-bit magnitude in one bit
// per cycle and then fixes the sign. One operation is in work at a time;
// req is ready whenever the sequencer is idle.
// A finished result sits in an output register, so a new request is taken
// while the receiver stalls; the sequencer then waits at its end until the
// output register is free. Reset empties the unit and loads the modulus
// with 998244353.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit_core #(
	parameter int RESIDUE_WIDTH = 31
) (
	input  logic      clk,
	input  logic      arst_n,
	mau_in_if.sink    req,
	mau_out_if.source rsp,
	mau_cfg_if.sink   cfg
);
	import mau_pkg::*;

	localparam int W  = RESIDUE_WIDTH;
	localparam int CW = $clog2(W);

	typedef enum logic [2:0] {
		ST_IDLE, ST_POW, ST_MUL, ST_RED, ST_RFIX, ST_FIN
	} state_t;

	typedef enum logic [1:0] {DST_ACC, DST_SQ, DST_RES} dest_t;

	state_t                   state_q;
	dest_t                    dest_q;
	logic [W-1:0]             mod_q;
	logic [W-1:0]             a_q;
	logic                     div_q;
	logic [W-1:0]             acc_q;
	logic [W-1:0]             sq_q;
	logic [EXP_WIDTH-1:0]     e_q;
	logic                     sqr_phase_q;
	logic [W-1:0]             mx_q;
	logic [W-1:0]             my_q;
	logic [W-1:0]             macc_q;
	logic [CW-1:0]            mcnt_q;
	logic [RAW_WIDTH-1:0]     rmag_q;
	logic                     rneg_q;
	logic [W-1:0]             racc_q;
	logic [RAW_CNT_WIDTH-1:0] rcnt_q;
	logic [W-1:0]             res_q;
	logic                     lt_q;
	logic                     eq_q;
	logic                     err_q;
	logic                     out_valid_q;
	logic [W-1:0]             out_res_q;
	logic                     out_lt_q;
	logic                     out_eq_q;
	logic                     out_err_q;

	logic                 uses_a;
	logic                 uses_b;
	logic                 err_in;
	logic                 mod_ok;
	logic [W:0]           add_sum;
	logic [W-1:0]         add_res;
	logic [W:0]           sub_v;
	logic [W-1:0]         div_exp;
	logic [RAW_WIDTH-1:0] raw_u;
	logic [RAW_WIDTH-1:0] raw_mag;
	logic [W+1:0]         mstep_v;
	logic [W+1:0]         mod1;
	logic [W+1:0]         mod2;
	logic [W-1:0]         mstep_n;
	logic [W:0]           rstep_v;
	logic [W-1:0]         rstep_n;
	logic [W-1:0]         rfix_res;
	logic                 out_load;

	assign req.ready         = (state_q == ST_IDLE);
	assign cfg.ready         = 1'b1;
	assign rsp.valid         = out_valid_q;
	assign rsp.result        = out_res_q;
	assign rsp.a_less_b      = out_lt_q;
	assign rsp.a_equal_b     = out_eq_q;
	assign rsp.operand_error = out_err_q;

	always_comb begin
		uses_a  = (req.func <= FN_POW);
		uses_b  = (req.func <= FN_DIV);
		err_in  = (uses_a && (req.operand_a >= mod_q)) || (uses_b && (req.operand_b >= mod_q));
		mod_ok  = (mod_q >= W'(2));
		add_sum = {1'b0, req.operand_a} + {1'b0, req.operand_b};
		add_res = (add_sum >= {1'b0, mod_q}) ? W'(add_sum - {1'b0, mod_q}) : add_sum[W-1:0];
		sub_v   = {1'b0, req.operand_a}
			+ ((req.operand_a >= req.operand_b) ? {(W+1){1'b0}} : {1'b0, mod_q})
			- {1'b0, req.operand_b};
		div_exp = mod_q - W'(2);
		raw_u   = req.raw_value;
		raw_mag = raw_u[RAW_WIDTH-1] ? (~raw_u + RAW_WIDTH'(1)) : raw_u;

		mod1    = {2'b00, mod_q};
		mod2    = {1'b0, mod_q, 1'b0};
		mstep_v = {1'b0, macc_q, 1'b0} + (my_q[W-1] ? {2'b00, mx_q} : {(W+2){1'b0}});
		if (mstep_v >= mod2) begin
			mstep_n = W'(mstep_v - mod2);
		end else if (mstep_v >= mod1) begin
			mstep_n = W'(mstep_v - mod1);
		end else begin
			mstep_n = mstep_v[W-1:0];
		end

		rstep_v  = {racc_q, rmag_q[RAW_WIDTH-1]};
		rstep_n  = (rstep_v >= {1'b0, mod_q}) ? W'(rstep_v - {1'b0, mod_q}) : rstep_v[W-1:0];
		rfix_res = (rneg_q && (racc_q != '0)) ? (mod_q - racc_q) : racc_q;

		out_load = (state_q == ST_FIN) && (!out_valid_q || rsp.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mod_q       <= W'(MODULUS_RESET);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				mod_q <= cfg.modulus;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						lt_q        <= (req.operand_a < req.operand_b);
						eq_q        <= (req.operand_a == req.operand_b);
						err_q       <= err_in;
						a_q         <= req.operand_a;
						div_q       <= 1'b0;
						sqr_phase_q <= 1'b0;
						acc_q       <= W'(1);
						if (err_in || !mod_ok) begin
							res_q   <= '0;
							state_q <= ST_FIN;
						end else begin
							unique case (req.func)
								FN_ADD: begin
									res_q   <= add_res;
									state_q <= ST_FIN;
								end
								FN_SUB: begin
									res_q   <= sub_v[W-1:0];
									state_q <= ST_FIN;
								end
								FN_MUL: begin
									mx_q    <= req.operand_a;
									my_q    <= req.operand_b;
									macc_q  <= '0;
									mcnt_q  <= '0;
									dest_q  <= DST_RES;
									state_q <= ST_MUL;
								end
								FN_DIV: begin
									if (req.operand_b == '0) begin
										res_q   <= '0;
										state_q <= ST_FIN;
									end else begin
										div_q   <= 1'b1;
										sq_q    <= req.operand_b;
										e_q     <= EXP_WIDTH'(div_exp);
										state_q <= ST_POW;
									end
								end
								FN_POW: begin
									sq_q    <= req.operand_a;
									e_q     <= req.exponent;
									state_q <= ST_POW;
								end
								FN_REDUCE: begin
									rmag_q  <= raw_mag;
									rneg_q  <= raw_u[RAW_WIDTH-1];
									racc_q  <= '0;
									rcnt_q  <= '0;
									state_q <= ST_RED;
								end
								default: begin
									res_q   <= '0;
									state_q <= ST_FIN;
								end
							endcase
						end
					end
				end

				ST_POW: begin
					if (e_q == '0) begin
						if (div_q) begin
							mx_q    <= a_q;
							my_q    <= acc_q;
							macc_q  <= '0;
							mcnt_q  <= '0;
							dest_q  <= DST_RES;
							state_q <= ST_MUL;
						end else begin
							res_q   <= acc_q;
							state_q <= ST_FIN;
						end
					end else if (!sqr_phase_q && e_q[0]) begin
						mx_q        <= acc_q;
						my_q        <= sq_q;
						macc_q      <= '0;
						mcnt_q      <= '0;
						dest_q      <= DST_ACC;
						sqr_phase_q <= 1'b1;
						state_q     <= ST_MUL;
					end else begin
						sqr_phase_q <= 1'b0;
						e_q         <= e_q >> 1;
						if (e_q[EXP_WIDTH-1:1] != '0) begin
							mx_q    <= sq_q;
							my_q    <= sq_q;
							macc_q  <= '0;
							mcnt_q  <= '0;
							dest_q  <= DST_SQ;
							state_q <= ST_MUL;
						end
					end
				end

				ST_MUL: begin
					macc_q <= mstep_n;
					my_q   <= my_q << 1;
					mcnt_q <= mcnt_q + CW'(1);
					if (mcnt_q == CW'(W - 1)) begin
						unique case (dest_q)
							DST_ACC: begin
								acc_q   <= mstep_n;
								state_q <= ST_POW;
							end
							DST_SQ: begin
								sq_q    <= mstep_n;
								state_q <= ST_POW;
							end
							default: begin
								res_q   <= mstep_n;
								state_q <= ST_FIN;
							end
						endcase
					end
				end

				ST_RED: begin
					racc_q <= rstep_n;
					rmag_q <= rmag_q << 1;
					rcnt_q <= rcnt_q + RAW_CNT_WIDTH'(1);
					if (rcnt_q == RAW_CNT_WIDTH'(RAW_WIDTH - 1)) begin
						state_q <= ST_RFIX;
					end
				end

				ST_RFIX: begin
					res_q   <= rfix_res;
					state_q <= ST_FIN;
				end

				ST_FIN: begin
					if (out_load) begin
						out_res_q   <= res_q;
						out_lt_q    <= lt_q;
						out_eq_q    <= eq_q;
						out_err_q   <= err_q;
						state_q     <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: tb/mau_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Modular arithmetic unit result checker
// Watches the request, response and modulus channels, keeps its own copy of
// the modulus, works out the expected result of every accepted request and
// compares each returned result field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module mau_checker #(
	parameter int RESIDUE_WIDTH = 31
) (
	input  logic clk,
	input  logic arst_n,
	mau_in_if    req,
	mau_out_if   rsp,
	mau_cfg_if   cfg,
	output int   failures,
	output int   pending
);
	import mau_pkg::*;

	typedef struct {
		logic [FUNC_WIDTH-1:0]    op;
		logic [RESIDUE_WIDTH-1:0] result;
		logic                     a_less_b;
		logic                     a_equal_b;
		logic                     operand_error;
	} outcome_t;

	logic [RESIDUE_WIDTH-1:0] modulus;
	outcome_t                 outcome_q[$];
	outcome_t                 oldest;
	int                       mismatch_count = 0;
	int                       result_index = 0;

	assign failures = mismatch_count;
	assign pending  = outcome_q.size();

	function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
		return (a * b) % m;
	endfunction

	function automatic logic [63:0] pow_mod(logic [63:0] base, logic [63:0] e, logic [63:0] m);
		logic [63:0] acc;
		logic [63:0] sq;
		acc = 64'd1 % m;
		sq  = base % m;
		while (e != 64'd0) begin
			if (e[0])
				acc = mul_mod(acc, sq, m);
			sq = mul_mod(sq, sq, m);
			e  = e >> 1;
		end
		return acc;
	endfunction

	function automatic outcome_t predict_outcome(
		logic [FUNC_WIDTH-1:0]    op,
		logic [RESIDUE_WIDTH-1:0] a,
		logic [RESIDUE_WIDTH-1:0] b,
		logic [EXP_WIDTH-1:0]     e,
		logic [RAW_WIDTH-1:0]     raw,
		logic [RESIDUE_WIDTH-1:0] mod_value
	);
		outcome_t    o;
		logic [63:0] m;
		logic [63:0] r;
		logic [63:0] mag;
		logic        uses_a;
		logic        uses_b;
		m      = 64'(mod_value);
		r      = 64'd0;
		uses_a = (op <= FN_POW);
		uses_b = (op <= FN_DIV);
		o.op            = op;
		o.a_less_b      = (a < b);
		o.a_equal_b     = (a == b);
		o.operand_error = (uses_a && a >= mod_value) || (uses_b && b >= mod_value);
		if (!o.operand_error && m >= 64'd2) begin
			case (op)
				FN_ADD: begin
					r = 64'(a) + 64'(b);
					if (r >= m)
						r = r - m;
				end
				FN_SUB: begin
					r = (a >= b) ? 64'(a) - 64'(b) : 64'(a) + m - 64'(b);
				end
				FN_MUL: begin
					r = mul_mod(64'(a), 64'(b), m);
				end
				FN_DIV: begin
					if (b != '0)
						r = mul_mod(64'(a), pow_mod(64'(b), m - 64'd2, m), m);
				end
				FN_POW: begin
					r = pow_mod(64'(a), 64'(e), m);
				end
				FN_REDUCE: begin
					if (raw[RAW_WIDTH-1]) begin
						mag = ~raw + 64'd1;
						r   = mag % m;
						if (r != 64'd0)
							r = m - r;
					end else begin
						r = raw % m;
					end
				end
				default: begin
					r = 64'd0;
				end
			endcase
		end
		o.result = r[RESIDUE_WIDTH-1:0];
		return o;
	endfunction

	task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			mismatch_count++;
			$display("%0t: result %0d (func %0d) %s expected %0d got %0d",
				$time, result_index, oldest.op, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus = MODULUS_RESET[RESIDUE_WIDTH-1:0];
			outcome_q.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (outcome_q.size() == 0) begin
					mismatch_count++;
					$display("%0t: result %0d arrived with no operation waiting, value %0d",
						$time, result_index, rsp.result);
				end else begin
					oldest = outcome_q.pop_front();
					check_field("result", 64'(oldest.result), 64'(rsp.result));
					check_field("a_less_b", 64'(oldest.a_less_b), 64'(rsp.a_less_b));
					check_field("a_equal_b", 64'(oldest.a_equal_b), 64'(rsp.a_equal_b));
					check_field("operand_error", 64'(oldest.operand_error),
						64'(rsp.operand_error));
				end
				result_index++;
			end
			if (cfg.valid && cfg.ready)
				modulus = cfg.modulus;
			if (req.valid && req.ready)
				outcome_q.push_back(predict_outcome(req.func, req.operand_a, req.operand_b,
					req.exponent, req.raw_value, modulus));
		end
	end

endmodule

// File: tb/modular_arithmetic_unit_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Modular arithmetic unit testbench
// Drives directed corner operations and random operations over a range of
// moduli, with random gaps and stalls on the request and response channels.
// A separate checker predicts and compares every result; this module only
// makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit_core_tb;
	import mau_pkg::*;

	localparam int RESIDUE_WIDTH = 31;

	localparam logic [FUNC_WIDTH-1:0]    OP_SPARE_6 = 3'd6;
	localparam logic [FUNC_WIDTH-1:0]    OP_SPARE_7 = 3'd7;
	localparam logic [RESIDUE_WIDTH-1:0] MOD_RESET  = MODULUS_RESET[RESIDUE_WIDTH-1:0];
	localparam logic [RESIDUE_WIDTH-1:0] RES_ONES   = '1;
	localparam logic [EXP_WIDTH-1:0]     EXP_ONES   = '1;
	localparam logic [RAW_WIDTH-1:0]     RAW_MIN    = {1'b1, {(RAW_WIDTH-1){1'b0}}};
	localparam logic [RAW_WIDTH-1:0]     RAW_MAX    = ~RAW_MIN;

	logic                     clk;
	logic                     arst_n;
	int                       failures;
	int                       pending;
	logic [RESIDUE_WIDTH-1:0] cur_modulus;
	int                       op_count[8];
	int                       sent = 0;
	int                       settings = 0;
	bit                       req_gapless = 1'b0;
	bit                       rsp_gapless = 1'b0;

	mau_in_if  #(.RESIDUE_WIDTH(RESIDUE_WIDTH)) req_ch();
	mau_out_if #(.RESIDUE_WIDTH(RESIDUE_WIDTH)) rsp_ch();
	mau_cfg_if #(.RESIDUE_WIDTH(RESIDUE_WIDTH)) cfg_ch();

	modular_arithmetic_unit_core #(.RESIDUE_WIDTH(RESIDUE_WIDTH)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	mau_checker #(.RESIDUE_WIDTH(RESIDUE_WIDTH)) result_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg      (cfg_ch),
		.failures (failures),
		.pending  (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(100_000_000);
		$display("Some tests failed");
		$finish;
	end

	function automatic logic [FUNC_WIDTH-1:0] pick_op();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 16)
			return FN_ADD;
		else if (sel < 32)
			return FN_SUB;
		else if (sel < 48)
			return FN_MUL;
		else if (sel < 60)
			return FN_DIV;
		else if (sel < 74)
			return FN_POW;
		else if (sel < 96)
			return FN_REDUCE;
		else if (sel < 98)
			return OP_SPARE_6;
		return OP_SPARE_7;
	endfunction

	function automatic logic [RESIDUE_WIDTH-1:0] pick_operand(logic [RESIDUE_WIDTH-1:0] m);
		int unsigned sel;
		sel = $urandom_range(0, 19);
		case (sel)
			0: return '0;
			1: return m - 1'b1;
			2: return m;
			3: return RES_ONES;
			4: return RESIDUE_WIDTH'($urandom);
			default: return RESIDUE_WIDTH'($urandom % m);
		endcase
	endfunction

	function automatic logic [EXP_WIDTH-1:0] pick_exponent();
		logic [EXP_WIDTH-1:0] full;
		int unsigned          len;
		full = {31'($urandom), $urandom};
		if ($urandom_range(0, 4) == 0)
			return full;
		len = $urandom_range(0, 20);
		return full & ((63'd1 << len) - 63'd1);
	endfunction

	function automatic logic [RAW_WIDTH-1:0] pick_raw();
		case ($urandom_range(0, 9))
			0: return RAW_MIN;
			1: return RAW_MAX;
			2: return 64'($urandom_range(0, 200)) - 64'd100;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_operation(
		input logic [FUNC_WIDTH-1:0]    op,
		input logic [RESIDUE_WIDTH-1:0] a,
		input logic [RESIDUE_WIDTH-1:0] b,
		input logic [EXP_WIDTH-1:0]     e,
		input logic [RAW_WIDTH-1:0]     raw
	);
		int gap;
		gap = req_gapless ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.func      <= op;
		req_ch.operand_a <= a;
		req_ch.operand_b <= b;
		req_ch.exponent  <= e;
		req_ch.raw_value <= raw;
		req_ch.valid     <= 1'b1;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
		op_count[op]++;
		sent++;
	endtask

	task automatic set_modulus(input logic [RESIDUE_WIDTH-1:0] m);
		req_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		cfg_ch.modulus <= m;
		cfg_ch.valid   <= 1'b1;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		cur_modulus = m;
		settings++;
	endtask

	task automatic run_random(input int count);
		logic [RESIDUE_WIDTH-1:0] a;
		logic [RESIDUE_WIDTH-1:0] b;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 39) == 0)
				req_gapless = !req_gapless;
			a = pick_operand(cur_modulus);
			b = ($urandom_range(0, 9) == 0) ? a : pick_operand(cur_modulus);
			send_operation(pick_op(), a, b, pick_exponent(), pick_raw());
		end
	endtask

	initial begin
		int stall;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				rsp_gapless = !rsp_gapless;
			stall = rsp_gapless ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	initial begin
		logic [RESIDUE_WIDTH-1:0] moduli [9];
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.func      = '0;
		req_ch.operand_a = '0;
		req_ch.operand_b = '0;
		req_ch.exponent  = '0;
		req_ch.raw_value = '0;
		rsp_ch.ready     = 1'b0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.modulus   = '0;
		cur_modulus      = MOD_RESET;
		foreach (op_count[i])
			op_count[i] = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_operation(FN_ADD, MOD_RESET - 1'b1, MOD_RESET - 1'b1, '0, '0);
		send_operation(FN_ADD, '0, '0, EXP_ONES, RAW_MIN);
		send_operation(FN_SUB, '0, MOD_RESET - 1'b1, '0, RAW_MAX);
		send_operation(FN_SUB, MOD_RESET - 1'b1, '0, '0, '0);
		send_operation(FN_SUB, 31'd5, 31'd5, '0, '0);
		send_operation(FN_MUL, MOD_RESET - 1'b1, MOD_RESET - 1'b1, '0, '0);
		send_operation(FN_MUL, '0, 31'd12345, '0, '0);
		send_operation(FN_DIV, 31'd7, '0, '0, '0);
		send_operation(FN_DIV, MOD_RESET - 1'b1, MOD_RESET - 1'b1, '0, '0);
		send_operation(FN_DIV, 31'd1, 31'd3, '0, '0);
		send_operation(FN_POW, '0, '0, '0, '0);
		send_operation(FN_POW, MOD_RESET - 1'b1, 31'd1, EXP_ONES, '0);
		send_operation(FN_POW, '0, 31'd9, 63'd5, '0);
		send_operation(FN_POW, 31'd2, RES_ONES, 63'd10, '0);
		send_operation(FN_REDUCE, RES_ONES, RES_ONES, '0, RAW_MIN);
		send_operation(FN_REDUCE, '0, '0, '0, RAW_MAX);
		send_operation(FN_REDUCE, '0, '0, '0, '1);
		send_operation(FN_REDUCE, '0, '0, '0, '0);
		send_operation(FN_REDUCE, '0, '0, '0, 64'd0 - 64'(MOD_RESET));
		send_operation(FN_ADD, MOD_RESET, 31'd1, '0, '0);
		send_operation(FN_MUL, 31'd1, RES_ONES, '0, '0);
		send_operation(FN_POW, MOD_RESET, '0, 63'd3, '0);
		send_operation(OP_SPARE_6, RES_ONES, '0, EXP_ONES, RAW_MIN);
		send_operation(OP_SPARE_7, 31'd3, 31'd3, '0, '0);
		send_operation(FN_DIV, MOD_RESET - 1'b1, MOD_RESET, '0, '0);

		// A modulus of one or zero is outside the usual range and forces a zero result.
		set_modulus(31'd1);
		for (int op = 0; op < 8; op++)
			send_operation(FUNC_WIDTH'(op), RESIDUE_WIDTH'($urandom_range(0, 2)),
				RESIDUE_WIDTH'($urandom_range(0, 2)), pick_exponent(), pick_raw());
		set_modulus(31'd0);
		for (int op = 0; op < 8; op++)
			send_operation(FUNC_WIDTH'(op), RESIDUE_WIDTH'($urandom_range(0, 2)),
				RESIDUE_WIDTH'($urandom_range(0, 2)), pick_exponent(), pick_raw());

		moduli = '{31'd2, RES_ONES, 31'd3, 31'd65537, 31'd1000000007, 31'h4000_0000,
			31'd1000, RESIDUE_WIDTH'($urandom_range(2, 32'h7fff_ffff)), MOD_RESET};
		foreach (moduli[i]) begin
			set_modulus(moduli[i]);
			run_random(86);
		end

		req_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);

		$display("Ran %0d operations: %0d add, %0d sub, %0d mul, %0d div, %0d pow,",
			sent, op_count[FN_ADD], op_count[FN_SUB], op_count[FN_MUL], op_count[FN_DIV],
			op_count[FN_POW]);
		$display("%0d reduce and %0d unused codes across %0d modulus writes from 0 up to",
			op_count[FN_REDUCE], op_count[OP_SPARE_6] + op_count[OP_SPARE_7], settings);
		$display("the full 31-bit value, with random stalls.");
		if (failures == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: filelist.f
rtl/mau_pkg.sv
rtl/mau_if.sv
rtl/modular_arithmetic_unit_core.sv
tb/mau_checker.sv
tb/modular_arithmetic_unit_core_tb.sv
